// File: src/sbph_pkg.sv
// Shared constants and helper functions for the spectrum bar and peak hold unit.
package sbph_pkg;

  localparam int NUM_COLUMNS_DEF = 64;
  localparam int MAX_ITER_DEF    = 9;

  localparam int COL_W   = 6;
  localparam int DEPTH   = 64;
  localparam int LEVEL_W = 5;
  localparam int HOLD_W  = 8;
  localparam int THR_W   = 16;
  localparam int FRAME_W = 12;
  localparam int PHASE_W = 11;
  localparam int WORD_W  = HOLD_W + 2 * LEVEL_W;

  localparam logic [31:0]        MAG_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0]        SQRT_START   = 32'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 5'd31;
  localparam logic [HOLD_W-1:0]  HOLD_RESET   = 8'd30;
  localparam logic [THR_W-1:0]   THRESH_RESET = 16'd16;
  localparam logic [FRAME_W-1:0] FRAME_LAST   = 12'd3071;
  localparam logic [11:0]        RING_LEN     = 12'd1536;

  localparam logic REG_PEAK_HOLD  = 1'b0;
  localparam logic REG_LOG_THRESH = 1'b1;

  // Position of the highest set bit; zero for an input of zero or one.
  function automatic logic [4:0] floor_log2(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (v[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: src/spectrum_bar_peak_hold_unit.sv
// Top level of the spectrum bar and peak hold unit: sequencer, root unit and column memory.
//
// Each input word on the s_axis channel carries one display column with the real and
// imaginary parts of its spectrum bin. The unit forms the squared magnitude, takes an
// integer Newton square root, compresses large values logarithmically and updates the
// falling bar, the held peak and the hold counter of that column. One output word on the
// m_axis channel follows each input word, carrying the column, bar height, peak height
// and colour phase.
// Items are handled one at a time. An item passes through the squaring and the magnitude
// sum, then each Newton step (one multiply, one test, a bit-serial restoring divider for a
// 32-bit quotient and an update), then the final multiply and test, and last the level and
// memory write-back before the output word. s_axis_tready rises in the same cycle as the
// output word appears. The column state lives in a single-port memory with a registered
// read at the column's address, taken ahead of the write-back. Reset clears the per-column
// valid bits, so every column reads as zero, and restores the frame counter and register
// defaults. The result waits in an output register; while the receiver stalls the next
// item may still be accepted and worked on, but its write-back waits until the output
// register is free.
module spectrum_bar_peak_hold_unit #(
  parameter int NUM_COLUMNS    = sbph_pkg::NUM_COLUMNS_DEF,
  parameter int MAX_ITERATIONS = sbph_pkg::MAX_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // column, bin_real, bin_imag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_column, bar_height, peak_height, color_phase
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sbph_pkg::*;

  localparam int N_W = $clog2(MAX_ITERATIONS + 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'((NUM_COLUMNS - 1) % DEPTH);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQR  = 9'b000000010,
    S_SUM  = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_TEST = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_STEP = 9'b001000000,
    S_LOG  = 9'b010000000,
    S_WB   = 9'b100000000
  } state_t;

  state_t state;

  logic [HOLD_W-1:0]  hold_cfg;
  logic [THR_W-1:0]   thr_cfg;
  logic [COL_W-1:0]   col_q;
  logic signed [15:0] re_q, im_q;
  logic signed [31:0] re_sq, im_sq;
  logic [31:0]        a_q, x_q, quo_q;
  logic [63:0]        sq_q;
  logic [31:0]        rem_q;
  logic [4:0]         dcnt;
  logic [N_W-1:0]     n_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic [FRAME_W-1:0] frame_q;
  logic [1:0]         mod3_q;
  logic [DEPTH-1:0]   valid_q;

  logic [WORD_W-1:0]  mem [DEPTH];
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  wr_data;
  logic               wb_go;

  logic [31:0]        mag_sum;
  logic               close;
  logic [32:0]        trial;
  logic [6:0]         lvl_raw;
  logic [LEVEL_W-1:0] bar_old, peak_old, bar_new, peak_new, shown;
  logic [HOLD_W-1:0]  hold_old, hold_new;
  logic [11:0]        phase_sum;
  logic [PHASE_W-1:0] phase;

  assign s_axis_tready = (state == S_IDLE);
  assign wb_go = (state == S_WB) && (!m_axis_tvalid || m_axis_tready);

  assign mag_sum = 32'(re_sq) + 32'(im_sq);
  assign close = (sq_q == {32'd0, a_q}) || (sq_q == {32'd0, a_q} + 64'd1) ||
                 (sq_q + 64'd1 == {32'd0, a_q});
  assign trial = {rem_q, quo_q[31]};

  always_comb begin
    if (x_q > {16'd0, thr_cfg}) begin
      lvl_raw = {floor_log2(x_q), x_q[1:0]};
    end else begin
      lvl_raw = (x_q > 32'd127) ? 7'd127 : x_q[6:0];
    end
  end

  always_comb begin
    {hold_old, peak_old, bar_old} = valid_q[col_q] ? rd_data : '0;
    if (lvl_q > bar_old) begin
      bar_new = lvl_q;
      shown   = lvl_q;
    end else begin
      shown   = bar_old;
      bar_new = frame_q[0] ? bar_old : bar_old - 5'd1;
    end
    peak_new = peak_old;
    hold_new = hold_old;
    if (shown > peak_old) begin
      peak_new = shown;
      hold_new = hold_cfg;
    end
    if (hold_new != '0) begin
      hold_new = hold_new - 8'd1;
    end else if (mod3_q == 2'd0) begin
      peak_new = peak_new - 5'd1;
    end
    wr_data   = {hold_new, peak_new, bar_new};
    phase_sum = {1'b0, frame_q[11:1]} + {3'd0, col_q, 3'd0} + {4'd0, col_q, 2'd0};
    phase     = (phase_sum >= RING_LEN) ? PHASE_W'(phase_sum - RING_LEN)
                                        : PHASE_W'(phase_sum);
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      mem[col_q] <= wr_data;
    end
    rd_data <= mem[col_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      hold_cfg      <= HOLD_RESET;
      thr_cfg       <= THRESH_RESET;
      frame_q       <= '0;
      mod3_q        <= '0;
      valid_q       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PEAK_HOLD:  hold_cfg <= cfg_data[HOLD_W-1:0];
          REG_LOG_THRESH: thr_cfg  <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && !wb_go) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            col_q <= s_axis_tdata[5:0];
            re_q  <= s_axis_tdata[21:6];
            im_q  <= s_axis_tdata[37:22];
            state <= S_SQR;
          end
        end
        S_SQR: begin
          re_sq <= re_q * re_q;
          im_sq <= im_q * im_q;
          state <= S_SUM;
        end
        S_SUM: begin
          a_q   <= (mag_sum > MAG_MAX) ? MAG_MAX : mag_sum;
          x_q   <= SQRT_START;
          n_q   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          sq_q  <= 64'(x_q) * 64'(x_q);
          state <= S_TEST;
        end
        S_TEST: begin
          if (close || n_q == N_W'(MAX_ITERATIONS) || x_q == '0) begin
            state <= S_LOG;
          end else begin
            rem_q <= '0;
            quo_q <= a_q;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, x_q}) begin
            rem_q <= 32'(trial - {1'b0, x_q});
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= trial[31:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          x_q   <= 32'(({1'b0, x_q} + {1'b0, quo_q}) >> 1);
          n_q   <= n_q + N_W'(1);
          state <= S_MUL;
        end
        S_LOG: begin
          if (lvl_raw > 7'(LEVEL_MAX)) begin
            lvl_q <= LEVEL_MAX;
          end else if (lvl_raw == '0) begin
            lvl_q <= 5'd1;
          end else begin
            lvl_q <= lvl_raw[LEVEL_W-1:0];
          end
          state <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            valid_q[col_q] <= 1'b1;
            m_axis_tvalid  <= 1'b1;
            m_axis_tdata   <= {5'd0, phase, peak_new, shown, col_q};
            if (col_q == LAST_COL) begin
              frame_q <= (frame_q == FRAME_LAST) ? '0 : frame_q + 12'd1;
              mod3_q  <= (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> x_q != '0)
    else $error("divider running with a zero divisor");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |-> n_q < N_W'(MAX_ITERATIONS))
    else $error("Newton step beyond the iteration limit");

  a_wb_out: assert property (@(posedge clk) disable iff (rst)
    wb_go |=> m_axis_tvalid && state == S_IDLE)
    else $error("write-back did not present a result");

  a_bar_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[10:6] != 5'd0)
    else $error("bar height of zero presented");
`endif

endmodule
